// ----- design/assert_macros.svh -----
// Assertion macros shared by the compass heading design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside of reset.
`define CMP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition that must never be seen at a clock edge outside of reset.
`define CMP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define CMP_ASSERT(lbl, prop, msg)
`define CMP_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ----- design/cmpcal_pkg.sv -----
// Shared types, constants and the CORDIC angle table of the compass heading block.
package cmpcal_pkg;

  localparam int AXIS_W     = 16;
  localparam int DIFF_W     = 17;
  localparam int HEADING_W  = 15;
  localparam int THRESH_W   = 16;
  localparam int LEN_W      = 10;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SPAN_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_LENGTH     = 1'b1;

  localparam logic [THRESH_W-1:0] SPAN_THRESHOLD_RST = 16'd100;
  localparam logic [LEN_W-1:0]    CAL_LENGTH_RST     = 10'd200;

  // Angles are degrees scaled by 2^16.
  localparam int ANGLE_W         = 26;
  localparam int ANGLE_TABLE_LEN = 24;
  localparam int ANGLE_IDX_W     = 5;
  localparam logic signed [ANGLE_W-1:0] HALF_TURN = 26'sd11796480;

  // Queue between the front and the CORDIC back end.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic                     calibrating;
    logic                     done;
    logic signed [AXIS_W-1:0] offset_x;
    logic signed [AXIS_W-1:0] offset_y;
    logic signed [AXIS_W-1:0] offset_z;
  } item_t;

  // atan(2^-i) in degrees times 2^16, rounded to nearest.
  function automatic logic signed [ANGLE_W-1:0] atan_deg16(input logic [ANGLE_IDX_W-1:0] idx);
    logic signed [ANGLE_W-1:0] a;
    case (idx)
      5'd0:    a = 26'sd2949120;
      5'd1:    a = 26'sd1740967;
      5'd2:    a = 26'sd919879;
      5'd3:    a = 26'sd466945;
      5'd4:    a = 26'sd234379;
      5'd5:    a = 26'sd117304;
      5'd6:    a = 26'sd58666;
      5'd7:    a = 26'sd29335;
      5'd8:    a = 26'sd14668;
      5'd9:    a = 26'sd7334;
      5'd10:   a = 26'sd3667;
      5'd11:   a = 26'sd1833;
      5'd12:   a = 26'sd917;
      5'd13:   a = 26'sd458;
      5'd14:   a = 26'sd229;
      5'd15:   a = 26'sd115;
      5'd16:   a = 26'sd57;
      5'd17:   a = 26'sd29;
      5'd18:   a = 26'sd14;
      5'd19:   a = 26'sd7;
      5'd20:   a = 26'sd4;
      5'd21:   a = 26'sd2;
      5'd22:   a = 26'sd1;
      default: a = 26'sd0;
    endcase
    return a;
  endfunction

endpackage

// ----- design/cmpcal_if.sv -----
// Valid/ready channel interfaces for magnetometer sample words and heading result words.
interface cmpcal_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 mode;
  logic signed [cmpcal_pkg::AXIS_W-1:0] axis_x;
  logic signed [cmpcal_pkg::AXIS_W-1:0] axis_y;
  logic signed [cmpcal_pkg::AXIS_W-1:0] axis_z;

  modport source (output valid, mode, axis_x, axis_y, axis_z, input ready);
  modport sink (input valid, mode, axis_x, axis_y, axis_z, output ready);
endinterface

interface cmpcal_out_if;
  logic                                    valid;
  logic                                    ready;
  logic        [cmpcal_pkg::HEADING_W-1:0] heading;
  logic                                    calibrating;
  logic                                    calibration_done;
  logic signed [cmpcal_pkg::AXIS_W-1:0]    offset_x_out;
  logic signed [cmpcal_pkg::AXIS_W-1:0]    offset_y_out;
  logic signed [cmpcal_pkg::AXIS_W-1:0]    offset_z_out;

  modport source (output valid, heading, calibrating, calibration_done,
                  offset_x_out, offset_y_out, offset_z_out, input ready);
  modport sink (input valid, heading, calibrating, calibration_done,
                offset_x_out, offset_y_out, offset_z_out, output ready);
endinterface

// ----- design/cmpcal_front.sv -----
// Front end: accepts sample words, runs min/max calibration and forms offset-corrected vectors.
`include "assert_macros.svh"

module cmpcal_front (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  cmpcal_in_if.sink                             in_i,
  input  logic [cmpcal_pkg::THRESH_W-1:0]       span_threshold_i,
  input  logic [cmpcal_pkg::LEN_W-1:0]          cal_length_i,
  input  logic                                  full_i,
  output logic                                  push_o,
  output cmpcal_pkg::item_t                     push_item_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_TRACK  = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;
  localparam logic [1:0] ST_PUSH   = 2'd3;

  localparam int AW = cmpcal_pkg::AXIS_W;
  localparam int DW = cmpcal_pkg::DIFF_W;

  logic [1:0] state_q, state_d;

  logic                 mode_q;
  logic signed [AW-1:0] smp_q [3];

  logic signed [AW-1:0] min_q [3];
  logic signed [AW-1:0] min_d [3];
  logic signed [AW-1:0] max_q [3];
  logic signed [AW-1:0] max_d [3];
  logic signed [AW-1:0] off_q [3];
  logic signed [AW-1:0] off_d [3];
  logic [cmpcal_pkg::LEN_W-1:0] count_q, count_d;
  logic                 active_q, active_d;
  logic                 done_q, done_d;

  logic signed [DW-1:0] sum_w  [3];
  logic signed [DW-1:0] mid_w  [3];
  logic        [DW-1:0] span_w [3];
  logic signed [DW-1:0] diff_w [3];

  logic accept;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  // Span and midpoint per axis; the midpoint rounds toward zero.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum_w[k]  = DW'(max_q[k]) + DW'(min_q[k]);
      mid_w[k]  = (sum_w[k] + DW'(sum_w[k][DW-1])) >>> 1;
      span_w[k] = DW'(max_q[k]) - DW'(min_q[k]);
      diff_w[k] = DW'(smp_q[k]) - DW'(off_q[k]);
    end
  end

  always_comb begin
    state_d  = state_q;
    min_d    = min_q;
    max_d    = max_q;
    off_d    = off_q;
    count_d  = count_q;
    active_d = active_q;
    done_d   = done_q;
    push_o   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_TRACK;
        end
      end
      ST_TRACK: begin
        done_d = 1'b0;
        if (mode_q) begin
          if (!active_q) begin
            for (int k = 0; k < 3; k++) begin
              min_d[k] = smp_q[k];
              max_d[k] = smp_q[k];
              off_d[k] = '0;
            end
            count_d  = '0;
            active_d = 1'b1;
          end else begin
            for (int k = 0; k < 3; k++) begin
              if (smp_q[k] > max_q[k]) begin
                max_d[k] = smp_q[k];
              end
              if (smp_q[k] < min_q[k]) begin
                min_d[k] = smp_q[k];
              end
            end
            count_d = count_q + 1'b1;
            done_d  = (count_d >= cal_length_i);
          end
        end
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (done_q) begin
          for (int k = 0; k < 3; k++) begin
            if (span_w[k] > DW'(span_threshold_i)) begin
              off_d[k] = mid_w[k][AW-1:0];
            end else begin
              off_d[k] = '0;
            end
          end
          active_d = 1'b0;
        end
        state_d = ST_PUSH;
      end
      ST_PUSH: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    push_item_o.dx          = diff_w[0];
    push_item_o.dy          = diff_w[1];
    push_item_o.calibrating = active_q;
    push_item_o.done        = done_q;
    push_item_o.offset_x    = off_q[0];
    push_item_o.offset_y    = off_q[1];
    push_item_o.offset_z    = off_q[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      active_q <= 1'b0;
      done_q   <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        min_q[k] <= '0;
        max_q[k] <= '0;
        off_q[k] <= '0;
      end
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      active_q <= active_d;
      done_q   <= done_d;
      min_q    <= min_d;
      max_q    <= max_d;
      off_q    <= off_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q   <= in_i.mode;
      smp_q[0] <= in_i.axis_x;
      smp_q[1] <= in_i.axis_y;
      smp_q[2] <= in_i.axis_z;
    end
  end

  `CMP_ASSERT(a_done_ends_run, push_o && push_item_o.done |-> !push_item_o.calibrating, "run still active on the word that ended it")
  `CMP_ASSERT_NEVER(a_push_while_full, push_o && full_i, "front pushed into a full queue")

endmodule

// ----- design/cmpcal_fifo.sv -----
// Short queue of corrected vectors between the calibration front end and the CORDIC.
`include "assert_macros.svh"

module cmpcal_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cmpcal_pkg::item_t item_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output cmpcal_pkg::item_t head_o
);

  cmpcal_pkg::item_t mem_q [cmpcal_pkg::QUEUE_DEPTH];

  logic [cmpcal_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [cmpcal_pkg::QCNT_W-1:0] count_q;

  assign full_o  = (count_q == cmpcal_pkg::QCNT_W'(cmpcal_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  `CMP_ASSERT_NEVER(a_pop_empty, pop_i && empty_o, "pop from an empty queue")
  `CMP_ASSERT(a_count_bound, count_q <= cmpcal_pkg::QCNT_W'(cmpcal_pkg::QUEUE_DEPTH), "queue count beyond depth")

endmodule

// ----- design/cmpcal_cordic.sv -----
// Back end: iterative vectoring CORDIC that turns a corrected vector into a heading word.
`include "assert_macros.svh"

module cmpcal_cordic #(
  parameter int HEADING_FRAC_BITS = 6,
  parameter int CORDIC_STEPS      = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  cmpcal_pkg::item_t head_i,
  output logic              pop_o,
  cmpcal_out_if.source      out_o
);

  localparam int STEPS = (CORDIC_STEPS < cmpcal_pkg::ANGLE_TABLE_LEN) ?
                         CORDIC_STEPS : cmpcal_pkg::ANGLE_TABLE_LEN;
  localparam int CNT_W = $clog2(STEPS + 1);
  localparam int XY_W  = 20;
  localparam int ZW    = cmpcal_pkg::ANGLE_W;
  localparam int HW    = ZW + 1;
  localparam int SH    = 16 - HEADING_FRAC_BITS;
  localparam logic [HW-1:0] ROUND_BIAS = HW'(1) << (SH - 1);
  localparam logic [HW-1:0] LIMIT      = HW'(360) << HEADING_FRAC_BITS;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_ROTATE = 2'd1;
  localparam logic [1:0] ST_ROUND  = 2'd2;

  logic [1:0] state_q, state_d;
  logic [CNT_W-1:0] step_q, step_d;

  logic signed [XY_W-1:0] x_q, x_d, y_q, y_d;
  logic signed [ZW-1:0]   z_q, z_d;
  logic signed [XY_W-1:0] xs, ys, x0, y0;
  logic [cmpcal_pkg::ANGLE_IDX_W-1:0] idx;

  cmpcal_pkg::item_t meta_q;

  logic signed [HW-1:0] h_s;
  logic        [HW-1:0] h_u, h_r, h_c;

  logic out_valid_q, out_valid_d;
  logic load_out;

  assign idx = cmpcal_pkg::ANGLE_IDX_W'(step_q);
  assign xs  = x_q >>> idx;
  assign ys  = y_q >>> idx;
  assign x0  = XY_W'(head_i.dx);
  assign y0  = XY_W'(head_i.dy);

  // Final angle shifted to 0..360 degrees, rounded half up and clamped.
  assign h_s = HW'(z_q) + HW'(cmpcal_pkg::HALF_TURN);
  assign h_u = h_s[HW-1] ? '0 : h_s;
  assign h_r = (h_u + ROUND_BIAS) >> SH;
  assign h_c = (h_r > LIMIT) ? LIMIT : h_r;

  assign out_o.valid = out_valid_q;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    x_d         = x_q;
    y_d         = y_q;
    z_d         = z_q;
    pop_o       = 1'b0;
    load_out    = 1'b0;
    out_valid_d = out_valid_q && !out_o.ready;
    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o  = 1'b1;
          step_d = '0;
          if (head_i.dx == '0 && head_i.dy == '0) begin
            z_d     = '0;
            state_d = ST_ROUND;
          end else begin
            state_d = ST_ROTATE;
            if (head_i.dx < 0) begin
              x_d = -x0;
              y_d = -y0;
              z_d = (head_i.dy >= 0) ? cmpcal_pkg::HALF_TURN : -cmpcal_pkg::HALF_TURN;
            end else begin
              x_d = x0;
              y_d = y0;
              z_d = '0;
            end
          end
        end
      end
      ST_ROTATE: begin
        if (y_q > 0) begin
          x_d = x_q + ys;
          y_d = y_q - xs;
          z_d = z_q + cmpcal_pkg::atan_deg16(idx);
        end else begin
          x_d = x_q - ys;
          y_d = y_q + xs;
          z_d = z_q - cmpcal_pkg::atan_deg16(idx);
        end
        step_d = step_q + 1'b1;
        if (step_q == CNT_W'(STEPS - 1)) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (!out_valid_q || out_o.ready) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
    if (pop_o) begin
      meta_q <= head_i;
    end
    if (load_out) begin
      out_o.heading          <= h_c[cmpcal_pkg::HEADING_W-1:0];
      out_o.calibrating      <= meta_q.calibrating;
      out_o.calibration_done <= meta_q.done;
      out_o.offset_x_out     <= meta_q.offset_x;
      out_o.offset_y_out     <= meta_q.offset_y;
      out_o.offset_z_out     <= meta_q.offset_z;
    end
  end

  `CMP_ASSERT(a_step_bound, step_q <= CNT_W'(STEPS), "CORDIC step count ran past its end")

endmodule

// ----- design/compass_heading_with_offset_calibration.sv -----
// Top level of the compass heading block with hard-iron offset calibration.
//
// Each input word carries one signed 16-bit X/Y/Z magnetometer sample and a mode bit; every
// word yields exactly one result word holding the heading atan2(y - offset_y, x - offset_x)
// plus 180 degrees in steps of 2^-HEADING_FRAC_BITS degree (0 to 360 degrees), together with
// the calibration status and the current X/Y/Z offsets. A calibration word (mode 1) that
// arrives while no run is active seeds the per-axis minimum and maximum and clears the
// offsets; later calibration words widen min and max, and the calibration_length-th word
// after the seed ends the run. Each axis offset then becomes the midpoint of min and max,
// rounded toward zero, when the span exceeds span_threshold, and zero otherwise. Measurement
// words during a run leave it unchanged, and the heading uses the offsets in force after the
// word, which are zero during a run. The front end steps each word through accept, track,
// finish and hand-off and takes no new word before the hand-off, which waits while the queue
// is full; the CORDIC back end loads a word, does one micro-rotation per cycle, then rounds,
// and the round waits while an earlier result is still held. A zero vector skips the
// rotations. A two-entry queue between the two ends and a registered output let the front
// end take the next word while a result still waits. Configuration writes are taken at
// any edge with cfg_we_i high and are meant to happen only while the block is idle.

module compass_heading_with_offset_calibration #(
  parameter int HEADING_FRAC_BITS = 6,
  parameter int CORDIC_STEPS      = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  cmpcal_in_if.sink                           in_i,
  cmpcal_out_if.source                        out_o,
  input  logic                                cfg_we_i,
  input  logic [cmpcal_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [cmpcal_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  logic [cmpcal_pkg::THRESH_W-1:0] span_threshold_q;
  logic [cmpcal_pkg::LEN_W-1:0]    cal_length_q;

  logic              push;
  logic              full;
  logic              pop;
  logic              empty;
  cmpcal_pkg::item_t push_item;
  cmpcal_pkg::item_t head_item;

  // Configuration registers; the length register keeps the low ten bits of the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_threshold_q <= cmpcal_pkg::SPAN_THRESHOLD_RST;
      cal_length_q     <= cmpcal_pkg::CAL_LENGTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cmpcal_pkg::REG_SPAN_THRESHOLD: span_threshold_q <= cfg_data_i;
        cmpcal_pkg::REG_CAL_LENGTH:     cal_length_q     <= cfg_data_i[cmpcal_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // The front end owns the calibration state and hands corrected vectors to the queue.
  cmpcal_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_i             (in_i),
    .span_threshold_i (span_threshold_q),
    .cal_length_i     (cal_length_q),
    .full_i           (full),
    .push_o           (push),
    .push_item_o      (push_item)
  );

  cmpcal_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head_item)
  );

  // The back end rotates one vector at a time and holds the finished word for the sink.
  cmpcal_cordic #(
    .HEADING_FRAC_BITS (HEADING_FRAC_BITS),
    .CORDIC_STEPS      (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head_item),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
